@@ rtl/core/hmbs_pkg.sv @@
package hmbs_pkg;

  localparam int MAP_WIDTH_DEF  = 256;
  localparam int MAP_LENGTH_DEF = 256;
  localparam int FRAC_BITS      = 8;
  localparam int FRAC_ONE       = 256;
  localparam int QUERY_W        = 18;
  localparam int HEIGHT_W       = 26;

  localparam logic [1:0] REP_BL = 2'd0;
  localparam logic [1:0] REP_BR = 2'd1;
  localparam logic [1:0] REP_TL = 2'd2;
  localparam logic [1:0] REP_TR = 2'd3;

  typedef struct packed {
    logic                 is_load;
    logic                 is_sample;
    logic [1:0]           wbank;
    logic [7:0]           wdata;
    logic                 xi0;
    logic                 xn0;
    logic                 zi0;
    logic                 zn0;
    logic [1:0]           rep;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fz;
  } hmbs_ctl_t;

  localparam int CTL_W = $bits(hmbs_ctl_t);

endpackage

@@ rtl/core/hmbs_ram.sv @@
module hmbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/core/hmbs_front.sv @@
module hmbs_front
  import hmbs_pkg::*;
#(
  parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
  parameter int MAP_LENGTH = MAP_LENGTH_DEF,
  parameter int CB         = 7,
  parameter int RB         = 7,
  parameter int AW         = 14
) (
  input  logic                     in_mode,
  input  logic [7:0]               in_pixel_x,
  input  logic [7:0]               in_pixel_z,
  input  logic [7:0]               in_pixel_value,
  input  logic signed [QUERY_W-1:0] in_query_x,
  input  logic signed [QUERY_W-1:0] in_query_z,
  output hmbs_ctl_t                ctl,
  output logic [3:0][AW-1:0]       addr
);

  localparam logic [9:0] W10 = 10'(MAP_WIDTH);
  localparam logic [9:0] L10 = 10'(MAP_LENGTH);

  logic [8:0]           xi, zi, xn, zn;
  logic [9:0]           xi_p1, zi_p1;
  logic [FRAC_BITS-1:0] fx, fz;
  logic                 in_map, px_ok, pz_ok;
  logic [7:0]           px_h, pz_h;
  logic [AW-1:0]        load_addr;
  logic [1:0]           rep;

  assign xi    = in_query_x[16:8];
  assign zi    = in_query_z[16:8];
  assign fx    = in_query_x[7:0];
  assign fz    = in_query_z[7:0];
  assign xi_p1 = {1'b0, xi} + 10'd1;
  assign zi_p1 = {1'b0, zi} + 10'd1;
  assign xn    = (xi_p1 < W10) ? xi_p1[8:0] : 9'(MAP_WIDTH - 1);
  assign zn    = (zi_p1 < L10) ? zi_p1[8:0] : 9'(MAP_LENGTH - 1);

  assign in_map = !in_query_x[QUERY_W-1] && !in_query_z[QUERY_W-1] &&
                  ({1'b0, xi} < W10) && ({1'b0, zi} < L10);

  assign px_ok     = {2'b00, in_pixel_x} < W10;
  assign pz_ok     = {2'b00, in_pixel_z} < L10;
  assign px_h      = {1'b0, in_pixel_x[7:1]};
  assign pz_h      = {1'b0, in_pixel_z[7:1]};
  assign load_addr = {pz_h[RB-1:0], px_h[CB-1:0]};

  always_comb begin
    if (zi[0]) begin
      rep = (fz >= fx) ? REP_BR : REP_TL;
    end else begin
      rep = (({1'b0, fx} + {1'b0, fz}) < 9'(FRAC_ONE)) ? REP_TR : REP_BL;
    end
  end

  always_comb begin
    logic [8:0] col9;
    logic [8:0] row9;
    logic [7:0] col8;
    logic [7:0] row8;
    col9 = '0;
    row9 = '0;
    col8 = '0;
    row8 = '0;
    for (int b = 0; b < 4; b++) begin
      col9 = (b[0] == xi[0]) ? xi : xn;
      row9 = (b[1] == zi[0]) ? zi : zn;
      col8 = col9[8:1];
      row8 = row9[8:1];
      addr[b] = in_mode ? {row8[RB-1:0], col8[CB-1:0]} : load_addr;
    end
  end

  always_comb begin
    ctl.is_load   = !in_mode && px_ok && pz_ok;
    ctl.is_sample = in_mode && in_map;
    ctl.wbank     = {in_pixel_z[0], in_pixel_x[0]};
    ctl.wdata     = in_pixel_value;
    ctl.xi0       = xi[0];
    ctl.xn0       = xn[0];
    ctl.zi0       = zi[0];
    ctl.zn0       = zn[0];
    ctl.rep       = rep;
    ctl.fx        = fx;
    ctl.fz        = fz;
  end

endmodule

@@ rtl/core/hmbs_queue.sv @@
module hmbs_queue #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] din,
  input  logic          pop,
  output logic [DW-1:0] dout,
  output logic          empty,
  output logic          full
);

  logic [DW-1:0] slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;
  logic          do_push, do_pop;

  assign empty   = (count_r == 2'd0);
  assign full    = (count_r == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

@@ rtl/core/hmbs_back.sv @@
module hmbs_back
  import hmbs_pkg::*;
#(
  parameter int AW = 14
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  hmbs_ctl_t                  q_ctl,
  input  logic [3:0][AW-1:0]         q_addr,
  output logic                       q_pop,
  output logic                       out_valid,
  output logic signed [HEIGHT_W-1:0] out_height,
  output logic                       out_inside_res
);

  logic [7:0]      rd [4];
  logic [3:0]      bank_we;

  logic            s1_vld_r;
  hmbs_ctl_t       s1_ctl_r;

  logic            s2_vld_r, s2_sample_r;
  logic signed [18:0] s2_top_r, s2_bot_r;
  logic [FRAC_BITS-1:0] s2_fz_r;

  logic            s3_vld_r, s3_sample_r;
  logic signed [HEIGHT_W-1:0] s3_p0_r, s3_p1_r;

  logic            out_vld_r, out_inside_r;
  logic signed [HEIGHT_W-1:0] out_height_r, out_height_nxt;

  logic signed [9:0]  bl, br, tl, tr;
  logic [8:0]         wx0, wx1, wz0, wz1;
  logic signed [19:0] top_full, bot_full;
  logic signed [28:0] p0_full, p1_full;

  assign q_pop = !q_empty;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      bank_we[b] = q_pop && q_ctl.is_load && (q_ctl.wbank == 2'(b));
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    hmbs_ram #(
      .WIDTH(8),
      .DEPTH(1 << AW)
    ) u_ram (
      .clk  (clk),
      .we   (bank_we[g]),
      .addr (q_addr[g]),
      .wdata(q_ctl.wdata),
      .rdata(rd[g])
    );
  end

  always_comb begin
    bl = $signed({2'b00, rd[{s1_ctl_r.zi0, s1_ctl_r.xi0}]});
    br = $signed({2'b00, rd[{s1_ctl_r.zi0, s1_ctl_r.xn0}]});
    tl = $signed({2'b00, rd[{s1_ctl_r.zn0, s1_ctl_r.xi0}]});
    tr = $signed({2'b00, rd[{s1_ctl_r.zn0, s1_ctl_r.xn0}]});
    unique case (s1_ctl_r.rep)
      REP_BR:  br = bl + tr - tl;
      REP_TL:  tl = tr + bl - br;
      REP_TR:  tr = tl + br - bl;
      default: bl = tl + br - tr;
    endcase
    wx1      = {1'b0, s1_ctl_r.fx};
    wx0      = 9'(FRAC_ONE) - wx1;
    top_full = tl * $signed({1'b0, wx0}) + tr * $signed({1'b0, wx1});
    bot_full = bl * $signed({1'b0, wx0}) + br * $signed({1'b0, wx1});
  end

  always_comb begin
    wz1     = {1'b0, s2_fz_r};
    wz0     = 9'(FRAC_ONE) - wz1;
    p0_full = s2_bot_r * $signed({1'b0, wz0});
    p1_full = s2_top_r * $signed({1'b0, wz1});
  end

  assign out_height_nxt = s3_sample_r ? (s3_p0_r + s3_p1_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= q_pop;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      out_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctl_r     <= q_ctl;
    s2_sample_r  <= s1_ctl_r.is_sample;
    s2_top_r     <= top_full[18:0];
    s2_bot_r     <= bot_full[18:0];
    s2_fz_r      <= s1_ctl_r.fz;
    s3_sample_r  <= s2_sample_r;
    s3_p0_r      <= p0_full[HEIGHT_W-1:0];
    s3_p1_r      <= p1_full[HEIGHT_W-1:0];
    out_inside_r <= s3_sample_r;
    out_height_r <= out_height_nxt;
  end

  assign out_valid      = out_vld_r;
  assign out_height     = out_height_r;
  assign out_inside_res = out_inside_r;

endmodule

@@ rtl/core/height_map_bilinear_sample_top.sv @@
// A result strobes on out_valid once the item has passed the queue, s1, s2, s3 and out.
// Throughput: one item per cycle; the four parity banks of the map return all
// corners of a cell in one read, and loads write one bank through the same port.
// busy rises only when the two-entry queue between classifier and datapath fills.
// Reset (rst_n low, synchronous) empties the queue and drops results in flight;
// the height map keeps its contents and is undefined until loaded.
module height_map_bilinear_sample_top
  import hmbs_pkg::*;
#(
  parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
  parameter int MAP_LENGTH = MAP_LENGTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_mode,
  input  logic [7:0]                 in_pixel_x,
  input  logic [7:0]                 in_pixel_z,
  input  logic [7:0]                 in_pixel_value,
  input  logic signed [QUERY_W-1:0]  in_query_x,
  input  logic signed [QUERY_W-1:0]  in_query_z,
  output logic                       out_valid,
  output logic signed [HEIGHT_W-1:0] out_height,
  output logic                       out_inside_res
);

  localparam int HALF_W = (MAP_WIDTH + 1) / 2;
  localparam int HALF_L = (MAP_LENGTH + 1) / 2;
  localparam int CB     = (HALF_W > 1) ? $clog2(HALF_W) : 1;
  localparam int RB     = (HALF_L > 1) ? $clog2(HALF_L) : 1;
  localparam int AW     = RB + CB;
  localparam int DW     = CTL_W + 4 * AW;

  hmbs_ctl_t          f_ctl, q_ctl;
  logic [3:0][AW-1:0] f_addr, q_addr;
  logic [DW-1:0]      q_din, q_dout;
  logic               q_empty, q_full, q_pop;

  hmbs_front #(
    .MAP_WIDTH (MAP_WIDTH),
    .MAP_LENGTH(MAP_LENGTH),
    .CB        (CB),
    .RB        (RB),
    .AW        (AW)
  ) u_front (
    .in_mode       (in_mode),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_z    (in_pixel_z),
    .in_pixel_value(in_pixel_value),
    .in_query_x    (in_query_x),
    .in_query_z    (in_query_z),
    .ctl           (f_ctl),
    .addr          (f_addr)
  );

  assign q_din = {f_ctl, f_addr};

  hmbs_queue #(
    .DW(DW)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (start),
    .din  (q_din),
    .pop  (q_pop),
    .dout (q_dout),
    .empty(q_empty),
    .full (q_full)
  );

  assign q_ctl  = q_dout[DW-1:4*AW];
  assign q_addr = q_dout[4*AW-1:0];
  assign busy   = q_full;

  hmbs_back #(
    .AW(AW)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_ctl         (q_ctl),
    .q_addr        (q_addr),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_height    (out_height),
    .out_inside_res(out_inside_res)
  );

endmodule

@@ rtl/core/hmbs_checker.sv @@
module hmbs_checker
  import hmbs_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       in_mode,
  input logic [7:0]                 in_pixel_x,
  input logic [7:0]                 in_pixel_z,
  input logic [7:0]                 in_pixel_value,
  input logic signed [QUERY_W-1:0]  in_query_x,
  input logic signed [QUERY_W-1:0]  in_query_z,
  input logic                       out_valid,
  input logic signed [HEIGHT_W-1:0] out_height,
  input logic                       out_inside_res
);

  logic       acc;
  logic       run5;
  logic [4:0] rst_hist_r;

  always_ff @(posedge clk) begin
    rst_hist_r <= {rst_hist_r[3:0], rst_n};
  end

  assign acc  = start && !busy;
  assign run5 = rst_n && (&rst_hist_r);

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    run5 |-> (out_valid == $past(acc, 5)))
    else $error("result strobe does not follow an accepted transfer");

  a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_inside_res) |-> (out_height == '0))
    else $error("nonzero height on an outside or load result");

  a_load_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (run5 && $past(acc && !in_mode, 5)) |-> !out_inside_res)
    else $error("load transfer reported inside");

  a_neg_outside: assert property (@(posedge clk) disable iff (!rst_n)
    (run5 && $past(acc && in_mode && in_query_x[QUERY_W-1], 5)) |-> !out_inside_res)
    else $error("negative coordinate reported inside");

endmodule

bind height_map_bilinear_sample_top hmbs_checker u_hmbs_checker (.*);

@@ tb/height_map_bilinear_sample_checker.sv @@
`timescale 1ns / 100ps

module height_map_bilinear_sample_checker
  import hmbs_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       in_mode,
  input  logic [7:0]                 in_pixel_x,
  input  logic [7:0]                 in_pixel_z,
  input  logic [7:0]                 in_pixel_value,
  input  logic signed [QUERY_W-1:0]  in_query_x,
  input  logic signed [QUERY_W-1:0]  in_query_z,
  input  logic                       out_valid,
  input  logic signed [HEIGHT_W-1:0] out_height,
  input  logic                       out_inside_res,
  output int                         pending_cnt,
  output int                         fail_cnt
);

  localparam int MAP_W = MAP_WIDTH_DEF;
  localparam int MAP_L = MAP_LENGTH_DEF;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] height;
    logic                       inside_res;
  } terrain_res_t;

  logic [7:0]   terrain_map [0:MAP_W*MAP_L-1];
  terrain_res_t height_q[$];
  terrain_res_t want;

  initial begin
    pending_cnt = 0;
    fail_cnt    = 0;
  end

  function automatic int corner(int x, int z);
    return int'(terrain_map[z*MAP_W + x]);
  endfunction

  function automatic terrain_res_t sample_height(logic signed [QUERY_W-1:0] qx,
                                                 logic signed [QUERY_W-1:0] qz);
    terrain_res_t r;
    int xi, zi, xn, zn, fx, fz;
    int bl, br, tl, tr, top_row, bot_row, h;
    r = '0;
    if (qx < 0 || qz < 0) return r;
    xi = int'(qx) >> FRAC_BITS;
    zi = int'(qz) >> FRAC_BITS;
    if (xi >= MAP_W || zi >= MAP_L) return r;
    fx = int'(qx) & (FRAC_ONE - 1);
    fz = int'(qz) & (FRAC_ONE - 1);
    xn = (xi + 1 < MAP_W) ? xi + 1 : MAP_W - 1;
    zn = (zi + 1 < MAP_L) ? zi + 1 : MAP_L - 1;
    bl = corner(xi, zi);
    br = corner(xn, zi);
    tl = corner(xi, zn);
    tr = corner(xn, zn);
    if (zi % 2 == 1) begin
      if (fz >= fx) br = bl + (tr - tl);
      else tl = tr + (bl - br);
    end else begin
      if (fx + fz < FRAC_ONE) tr = tl + (br - bl);
      else bl = tl + (br - tr);
    end
    top_row = tl * (FRAC_ONE - fx) + tr * fx;
    bot_row = bl * (FRAC_ONE - fx) + br * fx;
    h = bot_row * (FRAC_ONE - fz) + top_row * fz;
    r.height     = h[HEIGHT_W-1:0];
    r.inside_res = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      height_q.delete();
    end else begin
      if (out_valid) begin
        if (height_q.size() == 0) begin
          $error("unexpected result: height %0d inside_res %0d", out_height, out_inside_res);
          fail_cnt++;
        end else begin
          want = height_q.pop_front();
          if (out_height !== want.height) begin
            $error("height: expected %0d, got %0d", want.height, out_height);
            fail_cnt++;
          end
          if (out_inside_res !== want.inside_res) begin
            $error("inside_res: expected %0d, got %0d", want.inside_res, out_inside_res);
            fail_cnt++;
          end
        end
      end
      if (start && !busy) begin
        if (in_mode) begin
          height_q.push_back(sample_height(in_query_x, in_query_z));
        end else begin
          terrain_map[int'(in_pixel_z)*MAP_W + int'(in_pixel_x)] = in_pixel_value;
          height_q.push_back('0);
        end
      end
    end
    pending_cnt = height_q.size();
  end

endmodule

@@ tb/tb_height_map_bilinear_sample_top.sv @@
`timescale 1ns / 100ps

module tb_height_map_bilinear_sample_top;
  import hmbs_pkg::*;

  localparam int ITEM_GOAL   = 1970;
  localparam int QUIET_AFTER = 1700;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       in_mode = 1'b0;
  logic [7:0]                 in_pixel_x = '0;
  logic [7:0]                 in_pixel_z = '0;
  logic [7:0]                 in_pixel_value = '0;
  logic signed [QUERY_W-1:0]  in_query_x = '0;
  logic signed [QUERY_W-1:0]  in_query_z = '0;
  logic                       out_valid;
  logic signed [HEIGHT_W-1:0] out_height;
  logic                       out_inside_res;
  int                         pending_cnt;
  int                         fail_cnt;

  int n_items  = 0;
  int idle_pct = 25;
  int ready_cells[$];

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  height_map_bilinear_sample_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_z     (in_pixel_z),
    .in_pixel_value (in_pixel_value),
    .in_query_x     (in_query_x),
    .in_query_z     (in_query_z),
    .out_valid      (out_valid),
    .out_height     (out_height),
    .out_inside_res (out_inside_res)
  );

  height_map_bilinear_sample_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_z     (in_pixel_z),
    .in_pixel_value (in_pixel_value),
    .in_query_x     (in_query_x),
    .in_query_z     (in_query_z),
    .out_valid      (out_valid),
    .out_height     (out_height),
    .out_inside_res (out_inside_res),
    .pending_cnt    (pending_cnt),
    .fail_cnt       (fail_cnt)
  );

  task automatic transfer(logic mode, logic [7:0] px, logic [7:0] pz, logic [7:0] pv,
                          logic signed [QUERY_W-1:0] qx, logic signed [QUERY_W-1:0] qz);
    start          = 1'b1;
    in_mode        = mode;
    in_pixel_x     = px;
    in_pixel_z     = pz;
    in_pixel_value = pv;
    in_query_x     = qx;
    in_query_z     = qz;
    do @(posedge clk); while (busy);
    @(negedge clk);
    n_items++;
    if (n_items % 150 == 0) idle_pct = 15 * $urandom_range(0, 3);
    if (n_items < QUIET_AFTER && $urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  task automatic load_pixel(int x, int z, int v);
    transfer(1'b0, x[7:0], z[7:0], v[7:0], QUERY_W'($urandom()), QUERY_W'($urandom()));
  endtask

  task automatic sample_at(logic signed [QUERY_W-1:0] qx, logic signed [QUERY_W-1:0] qz);
    transfer(1'b1, 8'($urandom()), 8'($urandom()), 8'($urandom()), qx, qz);
  endtask

  function automatic int rand_height();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int pick_coord();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic sample_in_cell(int xi, int zi);
    int fx, fz;
    fx = $urandom_range(0, 255);
    case ($urandom_range(0, 5))
      0: fz = fx;
      1: begin
        fx = $urandom_range(1, 255);
        fz = 256 - fx;
      end
      2: fz = 255 - fx;
      default: fz = $urandom_range(0, 255);
    endcase
    sample_at({2'b00, xi[7:0], fx[7:0]}, {2'b00, zi[7:0], fz[7:0]});
  endtask

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int xi, zi, xn, zn, cell_id;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    load_pixel(0, 0, 0);
    load_pixel(1, 0, 255);
    load_pixel(0, 1, 255);
    load_pixel(1, 1, 0);
    sample_at(18'sd0, 18'sd0);
    sample_at(18'sd255, 18'sd0);
    sample_at(18'sd0, 18'sd255);
    sample_at(18'sd128, 18'sd128);
    sample_at(18'sd100, 18'sd155);
    load_pixel(2, 1, 255);
    load_pixel(1, 2, 0);
    load_pixel(2, 2, 255);
    sample_at(18'sd356, 18'sd356);
    sample_at(18'sd500, 18'sd300);
    sample_at(18'sd260, 18'sd510);
    load_pixel(255, 255, 200);
    sample_at(18'sd65535, 18'sd65535);
    sample_at(-18'sd1, 18'sd0);
    sample_at(18'sd0, -18'sd131072);
    sample_at(18'sd65536, 18'sd10);
    sample_at(18'sd10, 18'sd131071);
    ready_cells.push_back(0);
    ready_cells.push_back(257);
    ready_cells.push_back(65535);

    while (n_items < ITEM_GOAL) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          xi = pick_coord();
          zi = pick_coord();
          xn = (xi == 255) ? 255 : xi + 1;
          zn = (zi == 255) ? 255 : zi + 1;
          load_pixel(xi, zi, rand_height());
          load_pixel(xn, zi, rand_height());
          load_pixel(xi, zn, rand_height());
          load_pixel(xn, zn, rand_height());
          ready_cells.push_back(zi * 256 + xi);
          repeat ($urandom_range(1, 3)) sample_in_cell(xi, zi);
        end
        4, 5, 6: begin
          cell_id = ready_cells[$urandom_range(0, ready_cells.size() - 1)];
          sample_in_cell(cell_id % 256, cell_id / 256);
        end
        7, 8: begin
          case ($urandom_range(0, 3))
            0: sample_at(QUERY_W'($urandom_range(131072, 262143)), QUERY_W'($urandom()));
            1: sample_at(QUERY_W'($urandom()), QUERY_W'($urandom_range(131072, 262143)));
            2: sample_at(QUERY_W'($urandom_range(65536, 131071)), QUERY_W'($urandom()));
            default: sample_at(QUERY_W'($urandom()), QUERY_W'($urandom_range(65536, 131071)));
          endcase
        end
        default: load_pixel($urandom_range(0, 255), $urandom_range(0, 255), rand_height());
      endcase
    end
    start = 1'b0;

    while (pending_cnt != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
